// ----- rtl/qtl_pkg.sv -----
`timescale 1ns / 1ps

package qtl_pkg;

  // Byte classes produced by the front end
  localparam logic [2:0] CLS_WORD   = 3'd0;
  localparam logic [2:0] CLS_SPACE  = 3'd1;
  localparam logic [2:0] CLS_STRUCT = 3'd2;
  localparam logic [2:0] CLS_CMP    = 3'd3;
  localparam logic [2:0] CLS_QUOTE  = 3'd4;
  localparam logic [2:0] CLS_ARITH  = 3'd5;
  localparam logic [2:0] CLS_SEMI   = 3'd6;

  // Token kinds on the result side
  localparam logic [2:0] KIND_WORD   = 3'd0;
  localparam logic [2:0] KIND_STRUCT = 3'd1;
  localparam logic [2:0] KIND_CMP    = 3'd2;
  localparam logic [2:0] KIND_STR    = 3'd3;
  localparam logic [2:0] KIND_ARITH  = 3'd4;
  localparam logic [2:0] KIND_SEMI   = 3'd5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       token_start;
    logic [2:0] token_kind;
    logic       end_of_text;
  } out_item_t;

  // Classified byte held in the queue between front and back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [2:0] cls;
  } q_entry_t;

endpackage

// ----- rtl/qtl_front.sv -----
`timescale 1ns / 1ps

module qtl_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  qtl_pkg::in_item_t item,
  input  logic              push,
  output logic              full,
  output qtl_pkg::q_entry_t entry,
  output logic              entry_valid,
  input  logic              entry_take
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [2:0]        cls;
  qtl_pkg::q_entry_t mem [DEPTH];
  logic [IW-1:0]     wr_ptr;
  logic [IW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              wr_en;
  logic              rd_en;

  // Byte classification
  always_comb begin
    case (item.char_in) inside
      8'h20, [8'h09:8'h0D]:               cls = qtl_pkg::CLS_SPACE;
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C:  cls = qtl_pkg::CLS_STRUCT;
      8'h3C, 8'h3E, 8'h21, 8'h3D:         cls = qtl_pkg::CLS_CMP;
      8'h27, 8'h22:                       cls = qtl_pkg::CLS_QUOTE;
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25:  cls = qtl_pkg::CLS_ARITH;
      8'h3B:                              cls = qtl_pkg::CLS_SEMI;
      default:                            cls = qtl_pkg::CLS_WORD;
    endcase
  end

  assign full        = (count == CW'(DEPTH));
  assign entry_valid = (count != '0);
  assign wr_en       = push && !full;
  assign rd_en       = entry_take && entry_valid;
  assign entry       = mem[rd_ptr];

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{ch: item.char_in, last: item.text_end, cls: cls};
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/qtl_back.sv -----
`timescale 1ns / 1ps

module qtl_back (
  input  logic               clk,
  input  logic               rst,
  input  qtl_pkg::q_entry_t  entry,
  input  logic               entry_valid,
  output logic               entry_take,
  output qtl_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_CMP  = 2'd2;
  localparam logic [1:0] MODE_STR  = 2'd3;

  logic [1:0]         mode;
  logic [1:0]         mode_next;
  logic [1:0]         step_mode;
  logic               emit;
  logic               start;
  logic [2:0]         kind;
  logic               load;
  logic               res_valid;
  qtl_pkg::out_item_t res;
  qtl_pkg::out_item_t res_next;

  // Token state step for the entry at the head of the queue
  always_comb begin
    emit      = 1'b1;
    start     = 1'b1;
    kind      = qtl_pkg::KIND_WORD;
    step_mode = MODE_IDLE;
    if (mode == MODE_STR) begin
      start     = 1'b0;
      kind      = qtl_pkg::KIND_STR;
      step_mode = (entry.cls == qtl_pkg::CLS_QUOTE) ? MODE_IDLE : MODE_STR;
    end else if (mode == MODE_CMP && entry.cls == qtl_pkg::CLS_CMP) begin
      start = 1'b0;
      kind  = qtl_pkg::KIND_CMP;
    end else begin
      case (entry.cls)
        qtl_pkg::CLS_SPACE:  emit = 1'b0;
        qtl_pkg::CLS_STRUCT: kind = qtl_pkg::KIND_STRUCT;
        qtl_pkg::CLS_CMP: begin
          kind      = qtl_pkg::KIND_CMP;
          step_mode = MODE_CMP;
        end
        qtl_pkg::CLS_QUOTE: begin
          kind      = qtl_pkg::KIND_STR;
          step_mode = MODE_STR;
        end
        qtl_pkg::CLS_ARITH:  kind = qtl_pkg::KIND_ARITH;
        qtl_pkg::CLS_SEMI:   kind = qtl_pkg::KIND_SEMI;
        default: begin
          start     = (mode != MODE_WORD);
          step_mode = MODE_WORD;
        end
      endcase
    end
  end

  // Take an entry whenever the output register is free or being drained
  assign entry_take = entry_valid && (!res_valid || pop);
  assign load       = entry_take && (emit || entry.last);
  assign mode_next  = entry.last ? MODE_IDLE : step_mode;

  // Result word; a dropped final space becomes a bare end marker
  always_comb begin
    if (emit) begin
      res_next.char_out    = entry.ch;
      res_next.has_char    = 1'b1;
      res_next.token_start = start;
      res_next.token_kind  = kind;
    end else begin
      res_next.char_out    = '0;
      res_next.has_char    = 1'b0;
      res_next.token_start = 1'b0;
      res_next.token_kind  = qtl_pkg::KIND_WORD;
    end
    res_next.end_of_text = entry.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (entry_take) begin
        mode <= mode_next;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign result = res;
  assign empty  = !res_valid;

endmodule

// ----- rtl/query_text_lexer_core.sv -----
`timescale 1ns / 1ps

// Query text lexer: takes one byte of text per transaction and returns each
// kept byte with a token-start flag and a token kind; whitespace outside
// quoted strings is dropped, and the final byte of a text (text_end) always
// yields a result with end_of_text set. Throughput is one byte per cycle:
// the front end classifies a byte and writes it into a QUEUE_DEPTH-entry
// queue, and the back end reads one entry per cycle through a one-byte token
// state update into an output register. A byte accepted at one clock edge is
// on the result ports after the next edge at the earliest. Either side may
// stall; the queue absorbs up to QUEUE_DEPTH bytes before full rises.
module query_text_lexer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  qtl_pkg::in_item_t  item,
  input  logic               push,
  output logic               full,
  output qtl_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  qtl_pkg::q_entry_t entry;
  logic              entry_valid;
  logic              entry_take;

  qtl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .push        (push),
    .full        (full),
    .entry       (entry),
    .entry_valid (entry_valid),
    .entry_take  (entry_take)
  );

  qtl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (entry),
    .entry_valid (entry_valid),
    .entry_take  (entry_take),
    .result      (result),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

// ----- sim/query_text_lexer_core_tb.sv -----
`timescale 1ns / 1ps

module query_text_lexer_core_tb;

  // Lexer position between bytes
  localparam logic [1:0] LX_IDLE = 2'd0;
  localparam logic [1:0] LX_WORD = 2'd1;
  localparam logic [1:0] LX_CMP  = 2'd2;
  localparam logic [1:0] LX_STR  = 2'd3;

  // Byte codes the lexer treats specially
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_PCT    = "%";
  localparam logic [7:0] CH_SEMI   = ";";

  localparam int          BYTE_COUNT     = 1900;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Tracks the lexer state and the tokens still owed by the block
  class token_scoreboard;
    logic [1:0]         lex_state;
    qtl_pkg::out_item_t tokens_due[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        bare_marks;

    function new();
      lex_state  = LX_IDLE;
      mismatches = 0;
      checked    = 0;
      bare_marks = 0;
    endfunction

    static function bit is_space(logic [7:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    static function bit is_struct(logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
             c == CH_RBRACK || c == CH_COMMA;
    endfunction

    static function bit is_cmp(logic [7:0] c);
      return c == CH_LT || c == CH_GT || c == CH_BANG || c == CH_EQ;
    endfunction

    static function bit is_quote(logic [7:0] c);
      return c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    static function bit is_arith(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
             c == CH_SLASH || c == CH_PCT;
    endfunction

    static function bit is_plain(logic [7:0] c);
      return !(is_space(c) || is_struct(c) || is_cmp(c) || is_quote(c) ||
               is_arith(c) || c == CH_SEMI);
    endfunction

    // Work out the token byte (if any) that an accepted input produces
    function void note_byte(qtl_pkg::in_item_t x);
      qtl_pkg::out_item_t tok;
      logic [1:0]         nxt;
      bit                 keep;
      logic [7:0]         c;
      c                 = x.char_in;
      keep              = 1'b1;
      tok               = '0;
      tok.token_start   = 1'b1;
      tok.token_kind    = qtl_pkg::KIND_WORD;
      nxt               = LX_IDLE;
      if (lex_state == LX_STR) begin
        tok.token_start = 1'b0;
        tok.token_kind  = qtl_pkg::KIND_STR;
        nxt             = is_quote(c) ? LX_IDLE : LX_STR;
      end else if (lex_state == LX_CMP && is_cmp(c)) begin
        tok.token_start = 1'b0;
        tok.token_kind  = qtl_pkg::KIND_CMP;
      end else if (is_space(c)) begin
        keep = 1'b0;
      end else if (is_struct(c)) begin
        tok.token_kind = qtl_pkg::KIND_STRUCT;
      end else if (is_cmp(c)) begin
        tok.token_kind = qtl_pkg::KIND_CMP;
        nxt            = LX_CMP;
      end else if (is_quote(c)) begin
        tok.token_kind = qtl_pkg::KIND_STR;
        nxt            = LX_STR;
      end else if (is_arith(c)) begin
        tok.token_kind = qtl_pkg::KIND_ARITH;
      end else if (c == CH_SEMI) begin
        tok.token_kind = qtl_pkg::KIND_SEMI;
      end else begin
        tok.token_start = (lex_state != LX_WORD);
        nxt             = LX_WORD;
      end
      // final byte of a text always closes the lexer
      lex_state = x.text_end ? LX_IDLE : nxt;
      if (keep) begin
        tok.char_out = c;
        tok.has_char = 1'b1;
      end else begin
        tok = '0;
      end
      tok.end_of_text = x.text_end;
      if (keep || x.text_end)
        tokens_due.insert(tokens_due.size(), tok);
    endfunction

    // Compare one popped result with the oldest owed token
    function void check_token(qtl_pkg::out_item_t got);
      qtl_pkg::out_item_t want;
      if (tokens_due.size() == 0) begin
        $error("result with nothing pending: char_out %0h end_of_text %0b",
               got.char_out, got.end_of_text);
        mismatches++;
        return;
      end
      want = tokens_due[0];
      tokens_due.delete(0);
      checked++;
      if (!want.has_char)
        bare_marks++;
      if (got.char_out !== want.char_out) begin
        $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
        mismatches++;
      end
      if (got.has_char !== want.has_char) begin
        $error("has_char: expected %0b, got %0b", want.has_char, got.has_char);
        mismatches++;
      end
      if (got.token_start !== want.token_start) begin
        $error("token_start: expected %0b, got %0b", want.token_start,
               got.token_start);
        mismatches++;
      end
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, got %0d", want.token_kind,
               got.token_kind);
        mismatches++;
      end
      if (got.end_of_text !== want.end_of_text) begin
        $error("end_of_text: expected %0b, got %0b", want.end_of_text,
               got.end_of_text);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk  = 1'b0;
  logic               rst  = 1'b1;
  qtl_pkg::in_item_t  item = '0;
  logic               push = 1'b0;
  logic               full;
  qtl_pkg::out_item_t result;
  logic               empty;
  logic               pop  = 1'b0;

  token_scoreboard sb = new();

  logic [7:0]  text_bytes[$];
  bit          text_ends[$];
  int unsigned bytes_sent   = 0;
  int unsigned texts_sent   = 0;
  int unsigned burst_left   = 1;
  int unsigned idle_cycles  = 0;
  int unsigned pop_pct      = 100;
  int unsigned pop_phase    = 0;

  query_text_lexer_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both handshakes at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full)
        sb.note_byte(item);
      if (pop && !empty)
        sb.check_token(result);
    end
  end

  // Receiver: pop probability is re-drawn whenever pop_phase[5:0] is zero
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop_phase <= pop_phase + 1;
      if (pop_phase[5:0] == 6'd0) begin
        case ($urandom_range(0, 4))
          0, 1:    pop_pct <= 100;
          2:       pop_pct <= 70;
          3:       pop_pct <= 35;
          default: pop_pct <= 10;
        endcase
      end
      pop <= (pop_pct == 100) || ($urandom_range(1, 100) <= pop_pct);
    end
  end

  // Watchdog: too long with no transaction on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One byte; holds push until accepted, then maybe a gap between bursts
  task automatic send_byte(qtl_pkg::in_item_t x);
    int unsigned gap;
    push <= 1'b1;
    item <= x;
    do @(posedge clk); while (full);
    bytes_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text();
    qtl_pkg::in_item_t x;
    for (int i = 0; i < text_bytes.size(); i++) begin
      x.char_in  = text_bytes[i];
      x.text_end = text_ends[i];
      send_byte(x);
    end
    texts_sent++;
  endtask

  task automatic add_byte(logic [7:0] c);
    text_bytes.insert(text_bytes.size(), c);
    text_ends.insert(text_ends.size(), 1'b0);
  endtask

  // Load a string; text_end goes on its last byte
  task automatic load_text(string s);
    text_bytes.delete();
    text_ends.delete();
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
    text_ends[text_ends.size() - 1] = 1'b1;
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_SP;
    endcase
  endfunction

  function automatic logic [7:0] pick_struct();
    case ($urandom_range(0, 4))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] pick_arith();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_PCT;
    endcase
  endfunction

  function automatic logic [7:0] pick_cmp();
    case ($urandom_range(0, 3))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_BANG;
      default: return CH_EQ;
    endcase
  endfunction

  function automatic logic [7:0] pick_quote();
    return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!token_scoreboard::is_plain(c));
    return c;
  endfunction

  // Any byte but a quote; spaces are frequent inside strings
  function automatic logic [7:0] pick_str_body();
    logic [7:0] c;
    if ($urandom_range(0, 2) == 0)
      return pick_space();
    do c = 8'($urandom_range(0, 255)); while (token_scoreboard::is_quote(c));
    return c;
  endfunction

  // Well-formed text: tokens with random content and whitespace between
  task automatic build_query();
    int unsigned n;
    text_bytes.delete();
    text_ends.delete();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) add_byte(pick_plain());
        3:       add_byte(pick_struct());
        4:       add_byte(pick_arith());
        5:       add_byte(CH_SEMI);
        6, 7:    repeat ($urandom_range(1, 3)) add_byte(pick_cmp());
        default: begin
          add_byte(pick_quote());
          n = $urandom_range(0, 6);
          repeat (n) add_byte(pick_str_body());
          // leave some strings open
          if ($urandom_range(0, 4) != 0)
            add_byte(pick_quote());
        end
      endcase
      if ($urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 3)) add_byte(pick_space());
    end
    text_ends[text_ends.size() - 1] = 1'b1;
  endtask

  // Noise: arbitrary bytes with text_end set at random
  task automatic build_noise();
    text_bytes.delete();
    text_ends.delete();
    repeat ($urandom_range(1, 8)) begin
      text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
      text_ends.insert(text_ends.size(), $urandom_range(0, 7) == 0);
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme bytes, words, trailing whitespace as final byte
    text_bytes = '{"a", "b", 8'h00, 8'hFF, CH_TAB};
    text_ends  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    send_text();
    // every structural and arithmetic symbol and the semicolon, pair then third comparator, comparator as final byte
    load_text("([],)+-*/%;<=>x<");
    send_text();
    // open string ended by the text, then string closed by the other quote
    load_text("'q r");
    send_text();
    load_text("\"s'");
    send_text();

    // Random texts, mostly well formed
    while (bytes_sent < BYTE_COUNT) begin
      if ($urandom_range(0, 9) == 0)
        build_noise();
      else
        build_query();
      send_text();
    end
    push <= 1'b0;

    while (sb.tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; checked %0d token bytes and end marks",
             bytes_sent, texts_sent, sb.checked);
    $display("(%0d bare end markers), %0d field mismatches", sb.bare_marks,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.tokens_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
